// ----- src/dmcc_pkg.sv -----
// Shared codes and types for the direct-mapped cache controller.
// Command and result codes, stream widths, the access size limit and the stage-one operation type.
// No dependencies.
package dmcc_pkg;

	// Command codes carried on the slave tuser
	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_FILL   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Result kinds carried on the master tuser
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_REQ    = 2'd1;
	localparam logic [1:0] KIND_WRITE  = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// Stream widths
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 72;
	localparam int TUSER_W   = 2;

	// Access width limit in bytes
	localparam logic [2:0] MAX_SIZE = 3'd4;

	// Work held in stage one
	typedef enum logic [2:0] {
		OP_NONE,
		OP_REJECT,
		OP_WRITE,
		OP_READ,
		OP_FILL_DATA
	} op_t;

endpackage

// ----- src/dmcc_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
// Used for the byte lanes of the line store and for the tag store.
// No dependencies.
module dmcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read; a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/direct_mapped_cache_controller_core.sv -----
// Direct-mapped, write-through, write-allocate cache controller.
// Each item's result is registered in stage one and then in the output register before it reaches the master port.
// Throughput: one item per cycle for hits, writes, fill words and rejections while the master
// port takes results; a read miss holds the input while one request per line word goes out.
// Reset: the line and tag stores are swept to zero after reset, one word per cycle;
// no item is taken during the sweep.
module direct_mapped_cache_controller_core
	import dmcc_pkg::*;
#(
	parameter int LINE_BYTES = 32,
	parameter int LINES      = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// address [31:0], wr_data [63:32], size [66:64], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd [1:0]
	input  logic [TUSER_W-1:0]   s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// mem_addr [31:0], value [63:32], hit [64], zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	// kind [1:0]
	output logic [TUSER_W-1:0]   m_tuser,
	output logic                 m_tlast
);

	localparam int OFF_W     = $clog2(LINE_BYTES);
	localparam int IDX_W     = $clog2(LINES);
	localparam int BA_W      = IDX_W + OFF_W;
	localparam int TAG_FULL  = 32 - BA_W;
	localparam int TAG_W     = (TAG_FULL > 24) ? 24 : TAG_FULL;
	localparam int WPL       = LINE_BYTES / 4;
	localparam int CNT_W     = (WPL > 1) ? $clog2(WPL) : 1;
	localparam int MEM_WORDS = LINES * WPL;
	localparam int MEM_AW    = BA_W - 2;

	// Input fields
	logic [1:0]  in_cmd;
	logic [31:0] in_addr;
	logic [31:0] in_wdata;
	logic [2:0]  in_size;

	assign in_cmd   = s_tuser;
	assign in_addr  = s_tdata[31:0];
	assign in_wdata = s_tdata[63:32];
	assign in_size  = s_tdata[66:64];

	// Control state
	logic              clearing_q;
	logic [MEM_AW-1:0] clr_cnt_q;
	logic              fill_pending_q;
	logic [31:0]       pending_addr_q;
	logic [2:0]        pending_size_q;
	logic [CNT_W-1:0]  fill_count_q;

	// Stage one
	logic              valid_s1;
	op_t               op_s1;
	logic [31:0]       addr_s1;
	logic [31:0]       wdata_s1;
	logic [2:0]        size_s1;
	logic [3:0]        fwd_s1;
	logic [CNT_W-1:0]  req_s1;

	// Output register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_addr_q;
	logic [31:0] out_value_q;
	logic        out_hit_q;
	logic        out_last_q;

	// Accept-side decode
	logic              accept;
	logic              fill_acc;
	logic              fill_final;
	logic              size_ok;
	logic              rw_ok;
	logic              wr_ok;
	op_t               op_in;
	logic [31:0]       addr_in;
	logic [31:0]       acc_addr;
	logic [OFF_W-1:0]  acc_off;
	logic [IDX_W-1:0]  acc_idx;
	logic [IDX_W-1:0]  in_idx;
	logic [IDX_W-1:0]  p_idx;
	logic [OFF_W-1:0]  fill_off;
	logic [BA_W-1:0]   fill_ba;
	logic [1:0]        lane_i [4];
	logic [OFF_W:0]    lane_p [4];
	logic [BA_W-1:0]   lane_ba [4];

	// Line store lanes
	logic [3:0]             bank_we;
	logic [MEM_AW-1:0]      bank_waddr [4];
	logic [7:0]             bank_wdata [4];
	logic [MEM_AW-1:0]      bank_raddr [4];
	logic [3:0][7:0]        bank_rdata;
	logic [3:0]             fwd_in;

	// Tag store: valid bit above the tag
	logic                   tag_we;
	logic [IDX_W-1:0]       tag_waddr;
	logic [TAG_W:0]         tag_wdata;
	logic [TAG_W:0]         tag_rdata;

	// Stage-one result
	logic              tag_hit;
	logic              read_miss;
	logic              req_last;
	logic              has_result;
	logic              out_free;
	logic              s1_emit;
	logic              s1_done;
	logic [1:0]        res_kind;
	logic [31:0]       res_addr;
	logic [31:0]       res_value;
	logic              res_hit;
	logic              res_last;
	logic [31:0]       rd_value;
	logic [31:0]       wr_value;
	logic [31:0]       line_base;
	logic [1:0]        rd_lane [4];
	logic [OFF_W:0]    rd_pos [4];
	logic [7:0]        rd_byte [4];

	assign accept = s_tvalid && s_tready;

	// Decode the offered item and pick its operation
	always_comb begin
		size_ok    = (in_size != 3'd0) && (in_size <= MAX_SIZE);
		fill_acc   = (in_cmd == CMD_FILL) && fill_pending_q;
		fill_final = fill_acc && (fill_count_q == CNT_W'(WPL - 1));
		rw_ok      = ((in_cmd == CMD_READ) || (in_cmd == CMD_WRITE))
			&& !fill_pending_q && size_ok;
		wr_ok      = rw_ok && (in_cmd == CMD_WRITE);
		priority if (in_cmd == CMD_FILL) begin
			addr_in = fill_pending_q ? pending_addr_q : 32'd0;
			if (!fill_pending_q) begin
				op_in = OP_REJECT;
			end else if (fill_final) begin
				op_in = OP_FILL_DATA;
			end else begin
				op_in = OP_NONE;
			end
		end else if (in_cmd == CMD_UNUSED) begin
			op_in   = OP_REJECT;
			addr_in = 32'd0;
		end else if (!rw_ok) begin
			op_in   = OP_REJECT;
			addr_in = in_addr;
		end else if (in_cmd == CMD_WRITE) begin
			op_in   = OP_WRITE;
			addr_in = in_addr;
		end else begin
			op_in   = OP_READ;
			addr_in = in_addr;
		end
	end

	// Per-lane byte addresses of the access
	assign acc_addr = fill_acc ? pending_addr_q : in_addr;
	assign acc_off  = acc_addr[OFF_W-1:0];
	assign acc_idx  = acc_addr[OFF_W +: IDX_W];
	assign in_idx   = in_addr[OFF_W +: IDX_W];
	assign p_idx    = pending_addr_q[OFF_W +: IDX_W];
	assign fill_off = OFF_W'({fill_count_q, 2'b00});
	assign fill_ba  = {p_idx, fill_off};

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			lane_i[b]     = 2'(b) - acc_off[1:0];
			lane_p[b]     = {1'b0, acc_off} + (OFF_W + 1)'(lane_i[b]);
			lane_ba[b]    = {acc_idx, lane_p[b][OFF_W-1:0]};
			bank_raddr[b] = lane_ba[b][BA_W-1:2];
		end
	end

	// Line store writes: sweep, fill word, or store bytes
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bank_we[b]    = 1'b0;
			bank_waddr[b] = bank_raddr[b];
			bank_wdata[b] = 8'd0;
			fwd_in[b]     = 1'b0;
			if (clearing_q) begin
				bank_we[b]    = 1'b1;
				bank_waddr[b] = clr_cnt_q;
			end else if (accept && fill_acc) begin
				bank_we[b]    = 1'b1;
				bank_waddr[b] = fill_ba[BA_W-1:2];
				bank_wdata[b] = in_wdata[8*b +: 8];
				fwd_in[b]     = fill_final && (fill_ba[BA_W-1:2] == bank_raddr[b]);
			end else if (accept && wr_ok) begin
				bank_we[b]    = (3'(lane_i[b]) < in_size) && !lane_p[b][OFF_W];
				bank_wdata[b] = in_wdata[{lane_i[b], 3'b000} +: 8];
			end
		end
	end

	// Tag store writes: sweep, write allocate, or completed fill
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = in_idx;
		tag_wdata = {1'b1, in_addr[BA_W +: TAG_W]};
		if (clearing_q) begin
			tag_we    = {1'b0, clr_cnt_q} < (MEM_AW + 1)'(LINES);
			tag_waddr = clr_cnt_q[IDX_W-1:0];
			tag_wdata = '0;
		end else if (accept && wr_ok) begin
			tag_we = 1'b1;
		end else if (accept && fill_final) begin
			tag_we    = 1'b1;
			tag_waddr = p_idx;
			tag_wdata = {1'b1, pending_addr_q[BA_W +: TAG_W]};
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		dmcc_ram #(
			.WIDTH(8),
			.DEPTH(MEM_WORDS)
		) u_lane (
			.clk  (clk),
			.we   (bank_we[g]),
			.waddr(bank_waddr[g]),
			.wdata(bank_wdata[g]),
			.re   (accept),
			.raddr(bank_raddr[g]),
			.rdata(bank_rdata[g])
		);
	end

	dmcc_ram #(
		.WIDTH(TAG_W + 1),
		.DEPTH(LINES)
	) u_tags (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.re   (accept),
		.raddr(in_idx),
		.rdata(tag_rdata)
	);

	// Sweep the stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == MEM_AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Assemble bytes read from the line, forwarding the final fill word
	always_comb begin
		rd_value = 32'd0;
		wr_value = 32'd0;
		for (int i = 0; i < 4; i++) begin
			rd_lane[i] = addr_s1[1:0] + 2'(i);
			rd_pos[i]  = {1'b0, addr_s1[OFF_W-1:0]} + (OFF_W + 1)'(i);
			rd_byte[i] = fwd_s1[rd_lane[i]] ? wdata_s1[{rd_lane[i], 3'b000} +: 8]
				: bank_rdata[rd_lane[i]];
			if ((3'(i) < size_s1) && !rd_pos[i][OFF_W]) begin
				rd_value[8*i +: 8] = rd_byte[i];
			end
			if (3'(i) < size_s1) begin
				wr_value[8*i +: 8] = wdata_s1[8*i +: 8];
			end
		end
	end

	// Form the result of stage one
	assign tag_hit   = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == addr_s1[BA_W +: TAG_W]);
	assign read_miss = (op_s1 == OP_READ) && !tag_hit;
	assign req_last  = req_s1 == CNT_W'(WPL - 1);
	assign line_base = {addr_s1[31:OFF_W], {OFF_W{1'b0}}};

	always_comb begin
		has_result = 1'b1;
		res_kind   = KIND_REJECT;
		res_addr   = 32'd0;
		res_value  = 32'd0;
		res_hit    = 1'b0;
		res_last   = 1'b1;
		unique case (op_s1)
			OP_NONE: begin
				has_result = 1'b0;
			end
			OP_REJECT: begin
				res_addr = addr_s1;
			end
			OP_WRITE: begin
				res_kind  = KIND_WRITE;
				res_addr  = addr_s1;
				res_value = wr_value;
				res_hit   = tag_hit;
			end
			OP_READ: begin
				if (tag_hit) begin
					res_kind  = KIND_DATA;
					res_value = rd_value;
					res_hit   = 1'b1;
				end else begin
					res_kind = KIND_REQ;
					res_addr = line_base | {{(30 - CNT_W){1'b0}}, req_s1, 2'b00};
					res_last = req_last;
				end
			end
			OP_FILL_DATA: begin
				res_kind  = KIND_DATA;
				res_value = rd_value;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign s1_emit  = valid_s1 && has_result && out_free;
	assign s1_done  = valid_s1 && (!has_result || (out_free && (!read_miss || req_last)));
	assign s_tready = !clearing_q && (!valid_s1 || (s1_done && !read_miss));

	// Advance stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_NONE;
			req_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			op_s1    <= op_in;
			req_s1   <= '0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (s1_emit) begin
			req_s1 <= req_s1 + 1'b1;
		end
	end

	// Hold the item's payload in stage one
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= addr_in;
			wdata_s1 <= in_wdata;
			size_s1  <= fill_acc ? pending_size_q : in_size;
			fwd_s1   <= fwd_in;
		end
	end

	// Track the outstanding line fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_pending_q <= 1'b0;
			pending_addr_q <= 32'd0;
			pending_size_q <= 3'd0;
			fill_count_q   <= '0;
		end else if (s1_done && read_miss) begin
			fill_pending_q <= 1'b1;
			pending_addr_q <= addr_s1;
			pending_size_q <= size_s1;
			fill_count_q   <= '0;
		end else if (accept && fill_final) begin
			fill_pending_q <= 1'b0;
			fill_count_q   <= '0;
		end else if (accept && fill_acc) begin
			fill_count_q <= fill_count_q + 1'b1;
		end
	end

	// Output register: load a result or drop the transferred one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_emit) begin
			out_kind_q  <= res_kind;
			out_addr_q  <= res_addr;
			out_value_q <= res_value;
			out_hit_q   <= res_hit;
			out_last_q  <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - 65){1'b0}}, out_hit_q, out_value_q, out_addr_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- sim/tb_direct_mapped_cache_controller_core.sv -----
// Self-checking testbench for the direct-mapped write-through cache controller core.
// Directed table, then random access and fill sequences, checked against a local cache model.
// Depends on dmcc_pkg and direct_mapped_cache_controller_core.
`timescale 1ns / 100ps

module tb_direct_mapped_cache_controller_core
	import dmcc_pkg::*;
();

	localparam int LINE_BYTES     = 32;
	localparam int LINES          = 8;
	localparam int WORDS_PER_LINE = (LINE_BYTES + 3) / 4;
	localparam int MAX_RESULTS    = 8;
	localparam int PHASE_ITEMS    = 52;
	localparam int HOLD_CYCLES    = 300;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] mem_addr;
		logic [31:0] value;
		logic        hit;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
		logic [31:0] wr_data;
		logic [2:0]  size;
	} access_t;

	typedef struct packed {
		access_t acc;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [TUSER_W-1:0]   s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 m_tlast;

	// Cache model state
	bit          line_valid [LINES];
	logic [23:0] line_tag [LINES] = '{default: 24'h0};
	logic [7:0]  line_data [LINES*LINE_BYTES] = '{default: 8'h00};
	bit          fill_busy;
	logic [31:0] fill_addr;
	logic [2:0]  fill_size;
	int          fill_words;

	result_t  expected_results [$];
	dir_row_t dir_rows [$];
	int       err_count;
	int       snd_idle_pct;
	int       rcv_idle_pct;
	bit       long_hold_req;
	int       hold_left;
	int       stall_cycles;

	direct_mapped_cache_controller_core #(
		.LINE_BYTES(LINE_BYTES),
		.LINES     (LINES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Little-endian read of up to four bytes; bytes past the line end read as zero
	function automatic logic [31:0] line_read(input int idx, input int off, input int size);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < size && i < 4; i++) begin
			if (off + i < LINE_BYTES)
				v[8*i +: 8] = line_data[idx*LINE_BYTES + off + i];
		end
		return v;
	endfunction

	// Update the cache model with one access and return the results it causes
	function automatic int cache_predict(input access_t a, output result_t res [MAX_RESULTS]);
		int          idx;
		int          off;
		int          base;
		logic [23:0] tag;
		logic        hit_now;
		logic [31:0] mask;
		for (int k = 0; k < MAX_RESULTS; k++)
			res[k] = '0;
		if (a.cmd == CMD_FILL) begin
			if (!fill_busy) begin
				res[0] = '{KIND_REJECT, 32'd0, 32'd0, 1'b0, 1'b1};
				return 1;
			end
			idx  = (fill_addr / LINE_BYTES) % LINES;
			base = fill_words * 4;
			for (int i = 0; i < 4; i++) begin
				if (base + i < LINE_BYTES)
					line_data[idx*LINE_BYTES + base + i] = a.wr_data[8*i +: 8];
			end
			fill_words++;
			if (fill_words < WORDS_PER_LINE)
				return 0;
			line_valid[idx] = 1'b1;
			line_tag[idx]   = 24'(fill_addr / (LINE_BYTES * LINES));
			fill_busy       = 1'b0;
			fill_words      = 0;
			res[0] = '{KIND_DATA, 32'd0, line_read(idx, fill_addr % LINE_BYTES, fill_size),
				1'b0, 1'b1};
			return 1;
		end
		if (a.cmd == CMD_UNUSED) begin
			res[0] = '{KIND_REJECT, 32'd0, 32'd0, 1'b0, 1'b1};
			return 1;
		end
		if (fill_busy || a.size == 3'd0 || a.size > MAX_SIZE) begin
			res[0] = '{KIND_REJECT, a.address, 32'd0, 1'b0, 1'b1};
			return 1;
		end
		idx     = (a.address / LINE_BYTES) % LINES;
		off     = a.address % LINE_BYTES;
		tag     = 24'(a.address / (LINE_BYTES * LINES));
		hit_now = line_valid[idx] && line_tag[idx] == tag;
		// Write through, allocate without fill
		if (a.cmd == CMD_WRITE) begin
			for (int i = 0; i < a.size; i++) begin
				if (off + i < LINE_BYTES)
					line_data[idx*LINE_BYTES + off + i] = a.wr_data[8*i +: 8];
			end
			line_valid[idx] = 1'b1;
			line_tag[idx]   = tag;
			mask = (a.size >= 3'd4) ? 32'hFFFF_FFFF : (32'd1 << (8 * a.size)) - 32'd1;
			res[0] = '{KIND_WRITE, a.address, a.wr_data & mask, hit_now, 1'b1};
			return 1;
		end
		if (hit_now) begin
			res[0] = '{KIND_DATA, 32'd0, line_read(idx, off, a.size), 1'b1, 1'b1};
			return 1;
		end
		// Read miss: request every word of the aligned block
		for (int k = 0; k < WORDS_PER_LINE; k++)
			res[k] = '{KIND_REQ, a.address - off + 4 * k, 32'd0, 1'b0,
				k == WORDS_PER_LINE - 1};
		fill_busy  = 1'b1;
		fill_addr  = a.address;
		fill_size  = a.size;
		fill_words = 0;
		return WORDS_PER_LINE;
	endfunction

	task automatic add_row(input logic [1:0] cmd, input logic [31:0] address,
		input logic [31:0] wr_data, input logic [2:0] size, input logic typed,
		input logic [1:0] kind, input logic [31:0] mem_addr, input logic [31:0] value,
		input logic hit);
		dir_row_t row;
		row.acc   = '{cmd, address, wr_data, size};
		row.typed = typed;
		row.want  = '{kind, mem_addr, value, hit, 1'b1};
		dir_rows.push_back(row);
	endtask

	// Pick an address from a few tags so that hits, conflicts and evictions recur
	function automatic logic [31:0] pooled_address();
		logic [23:0] tag;
		case ($urandom_range(3))
			0: tag = 24'h000000;
			1: tag = 24'h000001;
			2: tag = 24'hFFFFFF;
			default: tag = 24'($urandom);
		endcase
		return {tag, 3'($urandom_range(LINES - 1)), 5'($urandom_range(LINE_BYTES - 1))};
	endfunction

	// Mostly well-formed traffic: accesses, and fill words while a fill is open
	function automatic access_t next_random_access();
		access_t a;
		int      r;
		r         = $urandom_range(99);
		a.address = pooled_address();
		a.wr_data = $urandom;
		a.size    = 3'($urandom_range(4, 1));
		a.cmd     = ($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE;
		if (fill_busy) begin
			if (r < 85)
				a.cmd = CMD_FILL;
			else if (r >= 93)
				a.cmd = CMD_UNUSED;
		end else if (r < 42) begin
			a.cmd = CMD_READ;
		end else if (r < 74) begin
			a.cmd = CMD_WRITE;
		end else if (r < 82) begin
			case ($urandom_range(3))
				0: a.size = 3'd0;
				1: a.size = 3'd5;
				2: a.size = 3'd6;
				default: a.size = 3'd7;
			endcase
		end else if (r < 87) begin
			a.cmd = CMD_UNUSED;
		end else if (r < 92) begin
			a.cmd = CMD_FILL;
		end else begin
			a.address = $urandom;
		end
		return a;
	endfunction

	// Offer one access, wait for its transfer, then record what it should produce
	task automatic send_access(input access_t a, input logic typed, input result_t want);
		result_t res [MAX_RESULTS];
		int      n;
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= a.cmd;
		s_tdata  <= {5'd0, a.size, a.wr_data, a.address};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n = cache_predict(a, res);
		if (typed)
			expected_results.push_back(want);
		else
			for (int k = 0; k < n; k++)
				expected_results.push_back(res[k]);
	endtask

	// Hold the input until every outstanding result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int snd_pct, input int rcv_pct);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_access(next_random_access(), 1'b0, '0);
		drain_results();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		err_count++;
		$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result mem_addr", m_tdata[31:0], 32'd0);
			return;
		end
		want = expected_results.pop_front();
		if (m_tuser != want.kind)
			report_mismatch("kind", m_tuser, want.kind);
		if (m_tdata[31:0] != want.mem_addr)
			report_mismatch("mem_addr", m_tdata[31:0], want.mem_addr);
		if (m_tdata[63:32] != want.value)
			report_mismatch("value", m_tdata[63:32], want.value);
		if (m_tdata[64] != want.hit)
			report_mismatch("hit", m_tdata[64], want.hit);
		if (m_tlast != want.last)
			report_mismatch("last", m_tlast, want.last);
	endtask

	// Result side: check each transfer, then pick next cycle's ready
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if (long_hold_req) begin
				hold_left     = HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Watchdog: end the run after a long stretch without any transfer
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// Stimulus
	initial begin
		arst_n        <= 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = CMD_READ;
		m_tready      = 1'b0;
		err_count     = 0;
		long_hold_req = 1'b0;
		fill_busy     = 1'b0;
		fill_addr     = '0;
		fill_size     = '0;
		fill_words    = 0;
		snd_idle_pct  = 24;
		rcv_idle_pct  = 47;

		// Rejections, write/read at the extremes, a miss with its fill
		add_row(CMD_FILL,   32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 1, KIND_REJECT, 0, 0, 0);
		add_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1, KIND_REJECT, 0, 0, 0);
		add_row(CMD_READ,   32'h0000_0040, 32'h0000_0000, 3'd0, 1, KIND_REJECT, 32'h40, 0, 0);
		add_row(CMD_WRITE,  32'h0000_0044, 32'hFFFF_FFFF, 3'd5, 1, KIND_REJECT, 32'h44, 0, 0);
		add_row(CMD_WRITE,  32'h0000_0048, 32'h0000_0000, 3'd7, 1, KIND_REJECT, 32'h48, 0, 0);
		add_row(CMD_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 1, KIND_WRITE, 0,
			32'hFFFF_FFFF, 0);
		add_row(CMD_READ,   32'h0000_0000, 32'h0000_0000, 3'd4, 1, KIND_DATA, 0,
			32'hFFFF_FFFF, 1);
		add_row(CMD_WRITE,  32'h0000_001E, 32'hA1B2_C3D4, 3'd4, 1, KIND_WRITE, 32'h1E,
			32'hA1B2_C3D4, 1);
		add_row(CMD_READ,   32'h0000_001F, 32'h0000_0000, 3'd4, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_WRITE,  32'h0000_0021, 32'h1234_5678, 3'd2, 1, KIND_WRITE, 32'h21,
			32'h0000_5678, 0);
		add_row(CMD_WRITE,  32'h0000_0023, 32'h9ABC_DEF0, 3'd3, 1, KIND_WRITE, 32'h23,
			32'h00BC_DEF0, 1);
		add_row(CMD_READ,   32'h0000_0020, 32'h0000_0000, 3'd4, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_READ,   32'h0000_0022, 32'h0000_0000, 3'd1, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_READ,   32'hFFFF_FFE7, 32'h0000_0000, 3'd2, 0, KIND_REQ, 0, 0, 0);
		add_row(CMD_READ,   32'h0000_0010, 32'h0000_0000, 3'd4, 1, KIND_REJECT, 32'h10, 0, 0);
		add_row(CMD_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1, 1, KIND_REJECT,
			32'hFFFF_FFFF, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'h0302_0100, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'h0000_0000, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'h5A5A_A5A5, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'h8765_4321, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'h0F1E_2D3C, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'hDEAD_BEEF, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_FILL,   32'h0000_0000, 32'hCAFE_F00D, 3'd0, 0, KIND_DATA, 0, 0, 0);
		add_row(CMD_READ,   32'hFFFF_FFFD, 32'h0000_0000, 3'd4, 0, KIND_DATA, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
		random_phase(24, 47);

		// Stall the result side for a long stretch while accesses keep coming
		long_hold_req = 1'b1;
		random_phase(47, 24);
		random_phase(0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- direct_mapped_cache_controller_core.f -----
src/dmcc_pkg.sv
src/dmcc_ram.sv
src/direct_mapped_cache_controller_core.sv
sim/tb_direct_mapped_cache_controller_core.sv
